@@ rtl/hbp_pkg.sv @@
// hbp_pkg: shared types and constants of the Huffman bit packer.
// No dependencies; imported by huffman_bit_packer.
package hbp_pkg;

	localparam int FUNC_W      = 2;
	localparam int SYM_W       = 8;
	localparam int LEN_IN_W    = 6;
	localparam int CODE_W      = 32;
	localparam int PEND_W      = 7;
	localparam int PEND_CNT_W  = 3;
	localparam int BYTE_W      = 8;
	localparam int TABLE_DEPTH = 256;
	localparam int IN_DATA_W   = 48;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2
	} func_t;

endpackage

@@ rtl/huffman_bit_packer.sv @@
// Huffman bit packer: code table in a 256-entry synchronous RAM, bit accumulator in flops.
// A request's first result reaches m_tdata through the stage-1 read register and the stage-2 output register.
// Throughput: one request per cycle while the output register can take results; a request giving n
// results (n up to 4) holds the output register until the output port has taken all n bytes, one per beat.
// Reset clears the accumulator and pipeline valids; the code table has no reset.
// Depends on hbp_pkg.
module huffman_bit_packer
	import hbp_pkg::*;
#(
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // func[1:0], symbol[9:2], code_len[15:10], code_bits[47:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BYTE_W-1:0]    m_tdata,  // out_byte[7:0]
	output logic                 m_tuser,  // is_trailer
	output logic                 m_tlast
);

	localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
	localparam int LW        = $clog2(LEN_LIMIT + 1);
	localparam int VW        = PEND_W + LEN_LIMIT;
	localparam int AW        = ((VW + BYTE_W - 1) / BYTE_W) * BYTE_W;
	localparam int NB_MAX    = VW / BYTE_W;
	localparam int RES_MAX   = (NB_MAX > 2) ? NB_MAX : 2;
	localparam int CW        = $clog2(RES_MAX + 1);
	localparam int TW        = $clog2(AW + 1);

	typedef struct packed {
		logic [LW-1:0]        len;
		logic [LEN_LIMIT-1:0] code;
	} entry_t;

	entry_t mem [TABLE_DEPTH];

	// input unpack
	func_t                in_func;
	logic [SYM_W-1:0]     in_sym;
	logic [LEN_IN_W-1:0]  in_len;
	logic [CODE_W-1:0]    in_code;
	logic [LW-1:0]        sat_len;
	logic                 s_acc;

	assign in_func = func_t'(s_tdata[FUNC_W-1:0]);
	assign in_sym  = s_tdata[FUNC_W +: SYM_W];
	assign in_len  = s_tdata[FUNC_W+SYM_W +: LEN_IN_W];
	assign in_code = s_tdata[FUNC_W+SYM_W+LEN_IN_W +: CODE_W];
	assign s_acc   = s_tvalid && s_tready;

	always_comb begin
		if (in_len > LEN_IN_W'(LEN_LIMIT)) begin
			sat_len = LW'(LEN_LIMIT);
		end else begin
			sat_len = in_len[LW-1:0];
		end
	end

	// stage 1: table read
	entry_t               rd_s1;
	func_t                func_s1;
	logic                 s1_valid_q;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			if (in_func == FUNC_LOAD) begin
				mem[in_sym] <= '{len: sat_len, code: in_code[LEN_LIMIT-1:0]};
			end
			rd_s1   <= mem[in_sym];
			func_s1 <= in_func;
		end
	end

	// accumulator
	logic [PEND_W-1:0]     pend_bits_q;
	logic [PEND_CNT_W-1:0] pend_cnt_q;

	logic [LEN_LIMIT-1:0]  code_masked;
	logic [VW-1:0]         joined;
	logic [TW-1:0]         total;
	logic [AW-1:0]         enc_word;
	logic [PEND_W-1:0]     enc_pend;
	logic [BYTE_W-1:0]     flush_byte;
	logic [AW-1:0]         flush_word;
	logic [CW-1:0]         s1_nres;
	logic [AW-1:0]         s1_word;

	assign code_masked = rd_s1.code & ~({LEN_LIMIT{1'b1}} << rd_s1.len);
	assign joined      = (VW'(pend_bits_q) << rd_s1.len) | VW'(code_masked);
	assign total       = TW'(pend_cnt_q) + TW'(rd_s1.len);
	assign enc_word    = AW'(joined) << (TW'(AW) - total);
	assign enc_pend    = joined[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[PEND_CNT_W-1:0]);
	assign flush_byte  = BYTE_W'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));

	always_comb begin
		if (pend_cnt_q != '0) begin
			flush_word = AW'({flush_byte, BYTE_W'(pend_cnt_q)}) << (AW - 2 * BYTE_W);
		end else begin
			flush_word = AW'(BYTE_W'(pend_cnt_q)) << (AW - BYTE_W);
		end
	end

	always_comb begin
		unique case (func_s1)
			FUNC_ENCODE: begin
				s1_nres = CW'(total >> 3);
				s1_word = enc_word;
			end
			FUNC_FLUSH: begin
				s1_nres = (pend_cnt_q != '0) ? CW'(2) : CW'(1);
				s1_word = flush_word;
			end
			default: begin
				s1_nres = '0;
				s1_word = enc_word;
			end
		endcase
	end

	// stage 2: output register, one byte per beat
	logic              s2_valid_q;
	logic [CW-1:0]     s2_cnt_q;
	logic [AW-1:0]     s2_word_q;
	logic              s2_flush_q;
	logic              s2_ready;
	logic              s1_adv;
	logic              s2_load;
	logic              m_acc;

	assign m_acc    = m_tvalid && m_tready;
	assign s2_ready = !s2_valid_q || (m_tready && s2_cnt_q == CW'(1));
	assign s1_adv   = s1_valid_q && (s1_nres == '0 || s2_ready);
	assign s2_load  = s1_adv && s1_nres != '0;
	assign s_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s2_cnt_q    <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (s1_adv) begin
				if (func_s1 == FUNC_ENCODE) begin
					pend_bits_q <= enc_pend;
					pend_cnt_q  <= total[PEND_CNT_W-1:0];
				end else if (func_s1 == FUNC_FLUSH) begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
				end
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
				s2_cnt_q   <= s1_nres;
			end else if (m_acc) begin
				s2_cnt_q <= s2_cnt_q - CW'(1);
				if (s2_cnt_q == CW'(1)) begin
					s2_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			s2_word_q  <= s1_word;
			s2_flush_q <= (func_s1 == FUNC_FLUSH);
		end else if (m_acc) begin
			s2_word_q <= s2_word_q << BYTE_W;
		end
	end

	assign m_tvalid = s2_valid_q;
	assign m_tdata  = s2_word_q[AW-1 -: BYTE_W];
	assign m_tlast  = (s2_cnt_q == CW'(1));
	assign m_tuser  = s2_flush_q && (s2_cnt_q == CW'(1));

`ifndef ASSERT_OFF
	a_trailer_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("trailer not marked last");

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> s2_cnt_q != '0)
		else $error("output valid with no results left");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |-> s2_valid_q)
		else $error("stage 1 stalled with empty output register");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load |=> s2_valid_q && s2_cnt_q != '0 && s2_cnt_q <= CW'(RES_MAX))
		else $error("bad result count loaded");
`endif

endmodule
